// ===== rtl/ugb_pkg.sv =====
// Shared types, constants and character-class functions for the UTF-8 grapheme marker.
`timescale 1ns / 1ps
`default_nettype none

package ugb_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int CP_W            = 21;
    localparam int OFF_OUT_W       = 16;
    localparam int CNT_W           = 3;
    localparam int RUN_W           = 2;
    localparam int EXT_N           = 26;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] IND_LO  = 21'h01F1E6;
    localparam logic [CP_W-1:0] IND_HI  = 21'h01F1FF;

    localparam logic [CP_W-1:0] EXT_LO [EXT_N] = '{
        21'h000300, 21'h000483, 21'h000591, 21'h0005BF, 21'h0005C1, 21'h0005C4,
        21'h0005C7, 21'h000610, 21'h00064B, 21'h000670, 21'h0006D6, 21'h0006DF,
        21'h0006E7, 21'h0006EA, 21'h000711, 21'h000730, 21'h000E31, 21'h000E34,
        21'h000E47, 21'h001AB0, 21'h001DC0, 21'h00200D, 21'h0020D0, 21'h00FE00,
        21'h00FE20, 21'h01F3FB
    };
    localparam logic [CP_W-1:0] EXT_HI [EXT_N] = '{
        21'h00036F, 21'h000489, 21'h0005BD, 21'h0005BF, 21'h0005C2, 21'h0005C5,
        21'h0005C7, 21'h00061A, 21'h00065F, 21'h000670, 21'h0006DC, 21'h0006E4,
        21'h0006E8, 21'h0006ED, 21'h000711, 21'h00074A, 21'h000E31, 21'h000E3A,
        21'h000E4E, 21'h001AFF, 21'h001DFF, 21'h00200D, 21'h0020FF, 21'h00FE0F,
        21'h00FE2F, 21'h01F3FF
    };

    // One request's worth of results: a run of replacements, then an optional final item.
    typedef struct packed {
        logic [RUN_W-1:0] run_cnt;
        logic             has_final;
        logic [CP_W-1:0]  cp;
        logic [CNT_W-1:0] cnt;
        logic             err;
        logic             gs;
    } t_job;

    function automatic logic is_ext(input logic [CP_W-1:0] cp);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < EXT_N; k++) begin
            if (cp >= EXT_LO[k] && cp <= EXT_HI[k]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic is_ind(input logic [CP_W-1:0] cp);
        return (cp >= IND_LO) && (cp <= IND_HI);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ugb_decode.sv =====
// Byte decoder state and per-request job formation with grapheme marking.
`timescale 1ns / 1ps
`default_nettype none

module ugb_decode #(
    parameter int OFFSET_BITS = ugb_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_end_of_text,
    output ugb_pkg::t_job               o_job,
    output logic                        o_job_vld,
    output logic [OFFSET_BITS-1:0]      o_run_off,
    output logic [OFFSET_BITS-1:0]      o_fin_off
);

    typedef enum logic [1:0] {
        CLS_ASCII,
        CLS_MULTI,
        CLS_BAD
    } t_cls;

    logic [ugb_pkg::CP_W-1:0]  r_pv, n_pv;
    logic [2:0]                r_len, n_len;
    logic [1:0]                r_rcv, n_rcv;
    logic [OFFSET_BITS-1:0]    r_pos, n_pos;
    logic [OFFSET_BITS-1:0]    r_sstart, n_sstart;
    logic                      r_started, n_started;
    logic                      r_bi, n_bi;
    logic                      r_ab, n_ab;

    always_comb begin
        logic                     cont;
        logic                     pending;
        logic [2:0]               rcv_inc;
        logic [ugb_pkg::CP_W-1:0] pv_c;
        logic [ugb_pkg::CP_W-1:0] lead_pv;
        logic [2:0]               lead_len;
        t_cls                     cls;
        logic                     st;
        logic                     bi;
        logic                     ab;
        logic                     ext;
        logic                     ind;

        n_pv      = r_pv;
        n_len     = r_len;
        n_rcv     = r_rcv;
        n_sstart  = r_sstart;
        o_job     = '0;
        o_run_off = r_sstart;
        o_fin_off = r_pos;

        cont     = (i_data_byte[7:6] == 2'b10);
        pending  = (r_len != 3'd0);
        rcv_inc  = {1'b0, r_rcv} + 3'd1;
        pv_c     = {r_pv[ugb_pkg::CP_W-7:0], i_data_byte[5:0]};
        lead_pv  = '0;
        lead_len = 3'd0;

        unique casez (i_data_byte)
            8'b0???????: cls = CLS_ASCII;
            8'b10??????: cls = CLS_BAD;
            8'b110?????: begin
                cls      = CLS_MULTI;
                lead_len = 3'd2;
                lead_pv  = {16'd0, i_data_byte[4:0]};
            end
            8'b1110????: begin
                cls      = CLS_MULTI;
                lead_len = 3'd3;
                lead_pv  = {17'd0, i_data_byte[3:0]};
            end
            8'b11110???: begin
                cls      = CLS_MULTI;
                lead_len = 3'd4;
                lead_pv  = {18'd0, i_data_byte[2:0]};
            end
            8'b11111???: cls = CLS_BAD;
        endcase

        if (pending && cont) begin
            if (rcv_inc >= r_len) begin
                o_job.has_final = 1'b1;
                o_job.cp        = pv_c;
                o_job.cnt       = r_len;
                o_job.err       = 1'b0;
                o_fin_off       = r_sstart;
                n_len           = 3'd0;
                n_rcv           = 2'd0;
                n_pv            = '0;
            end else begin
                n_pv  = pv_c;
                n_rcv = rcv_inc[1:0];
                if (i_end_of_text) begin
                    o_job.run_cnt = rcv_inc[1:0];
                end
            end
        end else begin
            o_job.run_cnt = pending ? r_rcv : 2'd0;
            n_len         = 3'd0;
            n_rcv         = 2'd0;
            n_pv          = '0;
            unique case (cls)
                CLS_ASCII: begin
                    o_job.has_final = 1'b1;
                    o_job.cp        = {13'd0, i_data_byte};
                    o_job.cnt       = 3'd1;
                    o_job.err       = 1'b0;
                end
                CLS_BAD: begin
                    o_job.has_final = 1'b1;
                    o_job.cp        = ugb_pkg::REPL_CP;
                    o_job.cnt       = 3'd1;
                    o_job.err       = 1'b1;
                end
                CLS_MULTI: begin
                    if (i_end_of_text) begin
                        o_job.has_final = 1'b1;
                        o_job.cp        = ugb_pkg::REPL_CP;
                        o_job.cnt       = 3'd1;
                        o_job.err       = 1'b1;
                    end else begin
                        n_len    = lead_len;
                        n_pv     = lead_pv;
                        n_rcv    = 2'd1;
                        n_sstart = r_pos;
                    end
                end
            endcase
        end

        // Replacements always open a new cluster and are never indicators.
        st = r_started;
        bi = r_bi;
        ab = r_ab;
        if (o_job.run_cnt != 2'd0) begin
            st = 1'b1;
            bi = 1'b0;
            ab = 1'b0;
        end
        ext = ugb_pkg::is_ext(o_job.cp);
        ind = ugb_pkg::is_ind(o_job.cp);
        if (o_job.has_final) begin
            if (st && ext) begin
                o_job.gs = 1'b0;
            end else if (st && bi && !ab && ind) begin
                o_job.gs = 1'b0;
                ab       = 1'b1;
            end else begin
                o_job.gs = 1'b1;
                bi       = ind;
                ab       = 1'b0;
            end
            st = 1'b1;
        end
        n_started = st;
        n_bi      = bi;
        n_ab      = ab;

        if (i_end_of_text) begin
            n_pv      = '0;
            n_len     = 3'd0;
            n_rcv     = 2'd0;
            n_pos     = '0;
            n_sstart  = '0;
            n_started = 1'b0;
            n_bi      = 1'b0;
            n_ab      = 1'b0;
        end else begin
            n_pos = r_pos + OFFSET_BITS'(1);
        end

        o_job_vld = (o_job.run_cnt != 2'd0) || o_job.has_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= '0;
            r_len     <= 3'd0;
            r_rcv     <= 2'd0;
            r_pos     <= '0;
            r_sstart  <= '0;
            r_started <= 1'b0;
            r_bi      <= 1'b0;
            r_ab      <= 1'b0;
        end else if (i_accept) begin
            r_pv      <= n_pv;
            r_len     <= n_len;
            r_rcv     <= n_rcv;
            r_pos     <= n_pos;
            r_sstart  <= n_sstart;
            r_started <= n_started;
            r_bi      <= n_bi;
            r_ab      <= n_ab;
        end
    end

    a_pending_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != 3'd0) |-> (r_rcv != 2'd0) && ({1'b0, r_rcv} < r_len))
        else $error("pending sequence has an impossible byte count");

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_text) |=> (r_pos == '0) && (r_len == 3'd0) && !r_started)
        else $error("end of text did not clear the decoder state");

endmodule

`default_nettype wire

// ===== rtl/ugb_emit.sv =====
// Job register and output register that walk one request's results onto the output.
`timescale 1ns / 1ps
`default_nettype none

module ugb_emit #(
    parameter int OFFSET_BITS = ugb_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_load,
    input  wire ugb_pkg::t_job                 i_job,
    input  wire logic [OFFSET_BITS-1:0]        i_run_off,
    input  wire logic [OFFSET_BITS-1:0]        i_fin_off,
    output logic                               o_ready,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [ugb_pkg::CP_W-1:0]           o_code_point,
    output logic [ugb_pkg::OFF_OUT_W-1:0]      o_start_offset,
    output logic [ugb_pkg::CNT_W-1:0]          o_byte_count,
    output logic                               o_decode_error,
    output logic                               o_grapheme_start,
    output logic                               o_last
);

    localparam int OUT_W = ugb_pkg::OFF_OUT_W;

    ugb_pkg::t_job                 r_job;
    logic                          r_job_vld;
    logic [OFFSET_BITS-1:0]        r_run_off;
    logic [OFFSET_BITS-1:0]        r_fin_off;
    logic                          r_out_vld;
    logic [ugb_pkg::CP_W-1:0]      r_cp;
    logic [OUT_W-1:0]              r_off;
    logic [ugb_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_err;
    logic                          r_gs;
    logic                          r_last;

    logic                          out_load;
    logic                          item_run;
    logic                          item_last;
    logic                          job_done;
    logic [ugb_pkg::CP_W-1:0]      item_cp;
    logic [OFFSET_BITS-1:0]        item_off;
    logic [ugb_pkg::CNT_W-1:0]     item_cnt;
    logic                          item_err;
    logic                          item_gs;

    always_comb begin
        out_load  = r_job_vld && (!r_out_vld || !i_stall);
        item_run  = (r_job.run_cnt != 2'd0);
        item_last = item_run ? ((r_job.run_cnt == 2'd1) && !r_job.has_final) : 1'b1;
        job_done  = out_load && item_last;
        o_ready   = !r_job_vld || job_done;
        item_cp   = item_run ? ugb_pkg::REPL_CP : r_job.cp;
        item_off  = item_run ? r_run_off : r_fin_off;
        item_cnt  = item_run ? 3'd1 : r_job.cnt;
        item_err  = item_run ? 1'b1 : r_job.err;
        item_gs   = item_run ? 1'b1 : r_job.gs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_job_load) begin
                r_job_vld <= 1'b1;
                r_job     <= i_job;
                r_run_off <= i_run_off;
                r_fin_off <= i_fin_off;
            end else if (job_done) begin
                r_job_vld <= 1'b0;
            end else if (out_load) begin
                r_job.run_cnt <= r_job.run_cnt - 2'd1;
                r_run_off     <= r_run_off + OFFSET_BITS'(1);
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
                r_cp      <= item_cp;
                r_off     <= OUT_W'(item_off);
                r_cnt     <= item_cnt;
                r_err     <= item_err;
                r_gs      <= item_gs;
                r_last    <= item_last;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_vld;
    assign o_code_point     = r_cp;
    assign o_start_offset   = r_off;
    assign o_byte_count     = r_cnt;
    assign o_decode_error   = r_err;
    assign o_grapheme_start = r_gs;
    assign o_last           = r_last;

    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_vld |-> (r_job.run_cnt != 2'd0) || r_job.has_final)
        else $error("held job has no result left");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_err) |->
            (r_cp == ugb_pkg::REPL_CP) && (r_cnt == 3'd1) && r_gs)
        else $error("replacement result has a wrong value, length or boundary");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_cnt != 3'd0) && (r_cnt <= 3'd4))
        else $error("byte count out of range");

    a_run_then_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !item_last && !i_job_load) |=> r_job_vld)
        else $error("job dropped before its last result");

endmodule

`default_nettype wire

// ===== rtl/utf8_grapheme_boundary_marker.sv =====
// Top level of the UTF-8 decoder with grapheme boundary marking.
//
//   Channel   Direction   Handshake                  Payload
//   in        request in  i_in_valid / o_in_stall    i_data_byte, i_end_of_text
//   out       result out  o_out_valid / i_out_stall  code point, offset, count, flags
//
// A byte is decoded in the cycle it is taken; while i_out_stall is low its results reach
// the output register one per cycle, so a byte with one result or none sustains one byte
// per cycle. A byte that flushes a broken sequence gives up to four results and holds
// o_in_stall while the job register drains.
// Reset is synchronous and active low and clears the decoder and both valid flags.
// A stalled output holds its result; a new byte is still taken while it waits if the job register is empty.
`timescale 1ns / 1ps
`default_nettype none

module utf8_grapheme_boundary_marker #(
    parameter int OFFSET_BITS = ugb_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_end_of_text,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [ugb_pkg::CP_W-1:0]           o_code_point,
    output logic [ugb_pkg::OFF_OUT_W-1:0]      o_start_offset,
    output logic [ugb_pkg::CNT_W-1:0]          o_byte_count,
    output logic                               o_decode_error,
    output logic                               o_grapheme_start,
    output logic                               o_last
);

    ugb_pkg::t_job           job;
    logic                    job_vld;
    logic [OFFSET_BITS-1:0]  run_off;
    logic [OFFSET_BITS-1:0]  fin_off;
    logic                    emit_ready;
    logic                    in_accept;

    assign o_in_stall = !emit_ready;
    assign in_accept  = i_in_valid && emit_ready;

    ugb_decode #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_job         (job),
        .o_job_vld     (job_vld),
        .o_run_off     (run_off),
        .o_fin_off     (fin_off)
    );

    ugb_emit #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_load       (in_accept && job_vld),
        .i_job            (job),
        .i_run_off        (run_off),
        .i_fin_off        (fin_off),
        .o_ready          (emit_ready),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_code_point     (o_code_point),
        .o_start_offset   (o_start_offset),
        .o_byte_count     (o_byte_count),
        .o_decode_error   (o_decode_error),
        .o_grapheme_start (o_grapheme_start),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

// ===== tb/utf8_grapheme_checker.sv =====
// Watches both channels of the UTF-8 grapheme marker, predicts each code point and compares.
`timescale 1ns / 1ps

module utf8_grapheme_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_end_of_text,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [ugb_pkg::CP_W-1:0]          i_code_point,
    input  logic [ugb_pkg::OFF_OUT_W-1:0]     i_start_offset,
    input  logic [ugb_pkg::CNT_W-1:0]         i_byte_count,
    input  logic                              i_decode_error,
    input  logic                              i_grapheme_start,
    input  logic                              i_last,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

    localparam logic [20:0] MARK_LO [26] = '{
        21'h000300, 21'h000483, 21'h000591, 21'h0005BF, 21'h0005C1, 21'h0005C4,
        21'h0005C7, 21'h000610, 21'h00064B, 21'h000670, 21'h0006D6, 21'h0006DF,
        21'h0006E7, 21'h0006EA, 21'h000711, 21'h000730, 21'h000E31, 21'h000E34,
        21'h000E47, 21'h001AB0, 21'h001DC0, 21'h00200D, 21'h0020D0, 21'h00FE00,
        21'h00FE20, 21'h01F3FB
    };
    localparam logic [20:0] MARK_HI [26] = '{
        21'h00036F, 21'h000489, 21'h0005BD, 21'h0005BF, 21'h0005C2, 21'h0005C5,
        21'h0005C7, 21'h00061A, 21'h00065F, 21'h000670, 21'h0006DC, 21'h0006E4,
        21'h0006E8, 21'h0006ED, 21'h000711, 21'h00074A, 21'h000E31, 21'h000E3A,
        21'h000E4E, 21'h001AFF, 21'h001DFF, 21'h00200D, 21'h0020FF, 21'h00FE0F,
        21'h00FE2F, 21'h01F3FF
    };

    typedef struct packed {
        logic [20:0] cp;
        logic [15:0] offset;
        logic [2:0]  count;
        logic        bad;
        logic        starts;
        logic        is_last;
    } code_point_t;

    code_point_t expected_code_points[$];
    code_point_t byte_results[$];

    logic [20:0] acc_value;
    logic [2:0]  seq_len;
    logic [2:0]  got_bytes;
    logic [15:0] next_pos;
    logic [15:0] lead_pos;
    logic        text_open;
    logic        ri_base;
    logic        ri_paired;
    int          mismatches = 0;
    int          checked = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = checked;

    function automatic logic is_mark(input logic [20:0] cp);
        for (int k = 0; k < 26; k++) begin
            if (cp >= MARK_LO[k] && cp <= MARK_HI[k]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic is_ri(input logic [20:0] cp);
        return (cp >= ugb_pkg::IND_LO) && (cp <= ugb_pkg::IND_HI);
    endfunction

    task automatic clear_decoder();
        acc_value = '0;
        seq_len   = '0;
        got_bytes = '0;
        next_pos  = '0;
        lead_pos  = '0;
        text_open = 1'b0;
        ri_base   = 1'b0;
        ri_paired = 1'b0;
    endtask

    task automatic add_code_point(input logic [20:0] cp, input logic [15:0] offset,
                                  input logic [2:0] count, input logic bad);
        code_point_t r;
        if (byte_results.size() >= 4) begin
            return;
        end
        r.starts = 1'b1;
        if (text_open && is_mark(cp)) begin
            r.starts = 1'b0;
        end else if (text_open && ri_base && !ri_paired && is_ri(cp)) begin
            r.starts  = 1'b0;
            ri_paired = 1'b1;
        end else begin
            ri_base   = is_ri(cp);
            ri_paired = 1'b0;
        end
        text_open = 1'b1;
        r.cp      = cp;
        r.offset  = offset;
        r.count   = count;
        r.bad     = bad;
        r.is_last = 1'b0;
        byte_results.push_back(r);
    endtask

    // Every byte of a broken sequence becomes a replacement at its own offset.
    task automatic flush_sequence();
        if (seq_len == 0) begin
            return;
        end
        for (int i = 0; i < got_bytes; i++) begin
            add_code_point(REPLACEMENT, lead_pos + 16'(i), 3'd1, 1'b1);
        end
        seq_len   = '0;
        got_bytes = '0;
        acc_value = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [15:0] here;
        logic        taken;
        code_point_t r;
        here  = next_pos;
        taken = 1'b0;
        byte_results.delete();
        if (seq_len != 0) begin
            if (b[7:6] == 2'b10) begin
                taken     = 1'b1;
                acc_value = {acc_value[14:0], b[5:0]};
                got_bytes = got_bytes + 3'd1;
                if (got_bytes >= seq_len) begin
                    add_code_point(acc_value, lead_pos, seq_len, 1'b0);
                    seq_len   = '0;
                    got_bytes = '0;
                    acc_value = '0;
                end
            end else begin
                flush_sequence();
            end
        end
        if (!taken) begin
            if (b[7] == 1'b0) begin
                add_code_point({13'd0, b}, here, 3'd1, 1'b0);
            end else if (b[7:5] == 3'b110) begin
                seq_len   = 3'd2;
                acc_value = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                seq_len   = 3'd3;
                acc_value = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                seq_len   = 3'd4;
                acc_value = {18'd0, b[2:0]};
            end else begin
                add_code_point(REPLACEMENT, here, 3'd1, 1'b1);
            end
            if (seq_len != 0) begin
                got_bytes = 3'd1;
                lead_pos  = here;
            end
        end
        if (eot) begin
            flush_sequence();
            clear_decoder();
        end else begin
            next_pos = here + 16'd1;
        end
        if (byte_results.size() > 0) begin
            r = byte_results.pop_back();
            r.is_last = 1'b1;
            byte_results.push_back(r);
        end
        foreach (byte_results[i]) begin
            expected_code_points.push_back(byte_results[i]);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 50) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        end
    endtask

    task automatic check_result();
        code_point_t want;
        if (expected_code_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 50) begin
                $error("code_point: expected none, got 0x%0h", i_code_point);
            end
            return;
        end
        want = expected_code_points.pop_front();
        checked++;
        compare_field("code_point", 32'(want.cp), 32'(i_code_point));
        compare_field("start_offset", 32'(want.offset), 32'(i_start_offset));
        compare_field("byte_count", 32'(want.count), 32'(i_byte_count));
        compare_field("decode_error", 32'(want.bad), 32'(i_decode_error));
        compare_field("grapheme_start", 32'(want.starts), 32'(i_grapheme_start));
        compare_field("last", 32'(want.is_last), 32'(i_last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            expected_code_points.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_data_byte, i_end_of_text);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
        end
        o_pending = expected_code_points.size();
    end

endmodule

// ===== tb/utf8_grapheme_boundary_marker_tb.sv =====
// Testbench top for the UTF-8 grapheme marker: drives byte texts and gives the verdict.
`timescale 1ns / 1ps

module utf8_grapheme_boundary_marker_tb;

    localparam int CYCLE_LIMIT = 1000000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic [7:0]                    i_data_byte = 8'd0;
    logic                          i_end_of_text = 1'b0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [ugb_pkg::CP_W-1:0]      o_code_point;
    logic [ugb_pkg::OFF_OUT_W-1:0] o_start_offset;
    logic [ugb_pkg::CNT_W-1:0]     o_byte_count;
    logic                          o_decode_error;
    logic                          o_grapheme_start;
    logic                          o_last;

    int         fail_count;
    int         pending;
    int         checked;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         bytes_sent = 0;
    int         texts_sent = 0;
    int         cycles = 0;
    logic [7:0] text_bytes[$];

    utf8_grapheme_boundary_marker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_text    (i_end_of_text),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_code_point     (o_code_point),
        .o_start_offset   (o_start_offset),
        .o_byte_count     (o_byte_count),
        .o_decode_error   (o_decode_error),
        .o_grapheme_start (o_grapheme_start),
        .o_last           (o_last)
    );

    utf8_grapheme_checker boundary_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_text    (i_end_of_text),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_code_point     (o_code_point),
        .i_start_offset   (o_start_offset),
        .i_byte_count     (o_byte_count),
        .i_decode_error   (o_decode_error),
        .i_grapheme_start (o_grapheme_start),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Returns at a falling edge with the request still valid, so back-to-back bytes follow
    // without a gap.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++) begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
        texts_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic add_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            text_bytes.push_back({1'b0, cp[6:0]});
        end else if (cp < 21'h800) begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    task automatic add_lead(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            2: begin
                text_bytes.push_back({3'b110, r[4:0]});
            end
            3: begin
                text_bytes.push_back({4'b1110, r[3:0]});
            end
            default: begin
                text_bytes.push_back({5'b11110, r[2:0]});
            end
        endcase
    endtask

    task automatic add_tail(input int n);
        logic [7:0] r;
        for (int i = 0; i < n; i++) begin
            r = 8'($urandom);
            text_bytes.push_back({2'b10, r[5:0]});
        end
    endtask

    // Mostly well-formed code points of every class, with some noise and broken sequences.
    task automatic build_random_text();
        int pieces;
        int kind;
        int k;
        int len;
        text_bytes.delete();
        pieces = $urandom_range(1, 10);
        repeat (pieces) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                add_code_point(21'($urandom_range(127)));
            end else if (kind < 35) begin
                k = $urandom_range(ugb_pkg::EXT_N - 1);
                add_code_point(21'(ugb_pkg::EXT_LO[k] +
                               $urandom_range(ugb_pkg::EXT_HI[k] - ugb_pkg::EXT_LO[k])));
            end else if (kind < 52) begin
                add_code_point(21'(ugb_pkg::IND_LO + $urandom_range(25)));
            end else if (kind < 77) begin
                len = $urandom_range(2, 4);
                add_lead(len);
                add_tail(len - 1);
            end else if (kind < 87) begin
                add_code_point(21'($urandom_range(21'h1FFFFF)));
            end else if (kind < 93) begin
                text_bytes.push_back(8'($urandom_range(255)));
            end else begin
                len = $urandom_range(2, 4);
                add_lead(len);
                add_tail($urandom_range(len - 2));
            end
        end
    endtask

    initial begin
        int  phase_start;
        int  base_send;
        int  base_recv;
        logic paused;
        paused = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            base_send = (phase == 0) ? 30 : (phase == 1) ? 56 : 0;
            base_recv = (phase == 0) ? 56 : (phase == 1) ? 30 : 0;
            send_idle_pct  = base_send;
            recv_stall_pct = base_recv;
            if (phase == 0) begin
                // A leading combining mark, ASCII extremes, a two-byte form, three
                // indicators, a broken four-byte form and a bad lead byte.
                text_bytes = '{8'hCC, 8'h80, 8'h7F, 8'h00, 8'hC3, 8'hA9,
                               8'hF0, 8'h9F, 8'h87, 8'hBA, 8'hF0, 8'h9F, 8'h87, 8'hBA,
                               8'hF0, 8'h9F, 8'h87, 8'hBA, 8'hF0, 8'h9F, 8'h87, 8'h41,
                               8'hFF};
                send_text();
                text_bytes = '{8'hE2, 8'h82};
                send_text();
                text_bytes = '{8'h80};
                send_text();
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 60) begin
                if (phase != 2 && $urandom_range(4) == 0) begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end else begin
                    send_idle_pct  = base_send;
                    recv_stall_pct = base_recv;
                end
                build_random_text();
                send_text();
                if (phase == 0 && !paused && bytes_sent - phase_start >= 30) begin
                    drain();
                    paused = 1'b1;
                end
            end
            if (phase == 2) begin
                // A complete four-byte form and an ASCII letter, then the text is cut off inside a three-byte form.
                text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41, 8'hE2, 8'h82};
                send_text();
            end
            drain();
        end
        repeat (8) @(posedge i_clk);
        $display("Sent %0d bytes in %0d texts and checked %0d decoded code points.",
                 bytes_sent, texts_sent, checked);
        $display("Covered bad and truncated sequences, marks and indicator pairs.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ugb_pkg.sv
rtl/ugb_decode.sv
rtl/ugb_emit.sv
rtl/utf8_grapheme_boundary_marker.sv
tb/utf8_grapheme_checker.sv
tb/utf8_grapheme_boundary_marker_tb.sv
